[hw/rtl/hdd_pkg.sv]
// Shared types and constants of the hashed duplicate detector.
// Used by the front, the back and the top level; depends on nothing.
`default_nettype none

package hdd_pkg;

   // field widths fixed by the interface
   localparam int VALUE_W  = 32;
   localparam int BUCKET_W = 11;
   localparam int BUCKET_RESET = 128;

   // remainder unit: 4 quotient bits per cycle
   localparam int DIV_BITS_PER_STEP = 4;
   localparam int DIV_STEPS = VALUE_W / DIV_BITS_PER_STEP;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   // set epoch tags kept next to each slot; tag zero marks an empty slot
   localparam int EPOCH_W = 8;
   localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               first_of_set;
   } hdd_item_type;

   typedef struct packed {
      logic is_duplicate;
      logic any_duplicate;
      logic not_stored;
   } hdd_result_type;

   typedef struct packed {
      logic [EPOCH_W-1:0] tag;
      logic [VALUE_W-1:0] value;
   } hdd_slot_type;

endpackage

`default_nettype wire

[hw/rtl/hdd_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package.
`default_nettype none

module hdd_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/hdd_fifo.sv]
// Two-entry register queue with push/full and pop/empty.
// Stand-alone; no package.
`default_nettype none

module hdd_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output      logic             full,
   input  wire logic             pop,
   output      logic [WIDTH-1:0] rd_data,
   output      logic             empty
);

   localparam logic [1:0] CountFull = 2'd2;

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             wr_fire;
   logic             rd_fire;

   assign full    = (count_ff == CountFull);
   assign empty   = (count_ff == 2'd0);
   assign wr_fire = push && !full;
   assign rd_fire = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_fire && !rd_fire) begin
         count_in = count_ff + 2'd1;
      end else if (rd_fire && !wr_fire) begin
         count_in = count_ff - 2'd1;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (wr_fire) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (rd_fire) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (wr_fire) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/hdd_front.sv]
// Front end: takes an item, forms the value's magnitude and its remainder
// by the bucket count (home slot), then hands item and home to the queue.
// Depends on hdd_pkg.
`default_nettype none

module hdd_front #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   input  wire hdd_pkg::hdd_item_type          item,
   output      logic                           full,
   input  wire logic                           hold,
   input  wire logic [$clog2(TABLE_DEPTH):0]   bucket_eff,
   output      logic                           q_push,
   output      hdd_pkg::hdd_item_type          q_item,
   output      logic [$clog2(TABLE_DEPTH)-1:0] q_home,
   input  wire logic                           q_full
);
   import hdd_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int BW = AW + 1;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } state_type;

   state_type            state_ff;
   hdd_item_type         item_ff;
   logic [VALUE_W-1:0]   dvd_ff;
   logic [VALUE_W-1:0]   dvd_in;
   logic [BW-1:0]        rem_ff;
   logic [BW-1:0]        rem_in;
   logic [BW:0]          trial;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [VALUE_W-1:0]   mag;

   // magnitude; the most negative value maps to 2^31 unsigned
   assign mag = item.value[VALUE_W-1] ? (VALUE_W'(0) - item.value) : item.value;

   assign full   = (state_ff != F_IDLE) || hold;
   assign q_push = (state_ff == F_PUSH) && !q_full;
   assign q_item = item_ff;
   assign q_home = rem_ff[AW-1:0];

   // restoring remainder, a few dividend bits per cycle
   always_comb begin
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      trial  = '0;
      for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
         trial  = {rem_in, dvd_in[VALUE_W-1]};
         dvd_in = {dvd_in[VALUE_W-2:0], 1'b0};
         if (trial >= {1'b0, bucket_eff}) begin
            trial = trial - {1'b0, bucket_eff};
         end
         rem_in = trial[BW-1:0];
      end
   end

   // sequencer: accept, iterate, hand off
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (push && !full) begin
                  item_ff  <= item;
                  dvd_ff   <= mag;
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= F_DIV;
               end
            end
            F_DIV: begin
               dvd_ff <= dvd_in;
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff + DIV_CNT_W'(1);
               if (cnt_ff == DIV_LAST) begin
                  state_ff <= F_PUSH;
               end
            end
            F_PUSH: begin
               if (!q_full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

[hw/rtl/hdd_back.sv]
// Back end: walks the probe chain in the slot memory, inserts or matches,
// keeps the set epoch and the sticky duplicate flag, and emits results.
// Depends on hdd_pkg and hdd_ram.
`default_nettype none

module hdd_back #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [$clog2(TABLE_DEPTH):0]   bucket_eff,
   input  wire logic                           q_empty,
   output      logic                           q_pop,
   input  wire hdd_pkg::hdd_item_type          q_item,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0] q_home,
   input  wire logic                           r_full,
   output      logic                           r_push,
   output      hdd_pkg::hdd_result_type        r_result,
   output      logic                           clearing
);
   import hdd_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int BW = AW + 1;
   localparam logic [AW-1:0] LastAddr = AW'(TABLE_DEPTH - 1);
   localparam logic [BW-1:0] EndPos   = BW'(TABLE_DEPTH);

   typedef enum logic [1:0] {
      B_CLEAR,
      B_IDLE,
      B_READ,
      B_EVAL
   } state_type;

   state_type          state_ff;
   logic [AW-1:0]      clr_ff;
   logic [EPOCH_W-1:0] epoch_ff;
   logic               dup_seen_ff;
   logic               pend_ff;
   hdd_item_type       item_ff;
   logic [BW-1:0]      pos_ff;
   logic [BW-1:0]      pos_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   hdd_slot_type       wr_slot;
   logic               rd_en;
   logic [$bits(hdd_slot_type)-1:0] rd_data;
   hdd_slot_type       slot;
   logic               hit;
   logic               free_slot;
   logic               past_end;

   hdd_ram #(
      .WIDTH ($bits(hdd_slot_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_slot),
      .rd_en   (rd_en),
      .rd_addr (pos_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // probe evaluation: a slot is live only if its tag is the current epoch
   assign slot      = hdd_slot_type'(rd_data);
   assign free_slot = (slot.tag != epoch_ff);
   assign hit       = !free_slot && (slot.value == item_ff.value);
   assign pos_in    = pos_ff + bucket_eff;
   assign past_end  = (pos_in >= EndPos);

   assign clearing = (state_ff == B_CLEAR);
   assign q_pop    = (state_ff == B_IDLE) && !q_empty && !r_full;
   assign rd_en    = (state_ff == B_READ);

   // memory writes: clearing sweep or insertion
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff[AW-1:0];
      wr_slot = '{tag: epoch_ff, value: item_ff.value};
      if (state_ff == B_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_slot = '{tag: EPOCH_NONE, value: '0};
      end else if ((state_ff == B_EVAL) && free_slot) begin
         wr_en = 1'b1;
      end
   end

   // result; the output queue had room when the item was taken
   assign r_push = (state_ff == B_EVAL) && (hit || free_slot || past_end);
   assign r_result = '{
      is_duplicate:  hit,
      any_duplicate: dup_seen_ff || hit,
      not_stored:    !hit && !free_slot
   };

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_CLEAR;
         clr_ff      <= '0;
         epoch_ff    <= EPOCH_FIRST;
         dup_seen_ff <= 1'b0;
         pend_ff     <= 1'b0;
      end else begin
         unique case (state_ff)
            B_CLEAR: begin
               if (clr_ff == LastAddr) begin
                  clr_ff   <= '0;
                  epoch_ff <= EPOCH_FIRST;
                  pend_ff  <= 1'b0;
                  state_ff <= pend_ff ? B_READ : B_IDLE;
               end else begin
                  clr_ff <= clr_ff + AW'(1);
               end
            end
            B_IDLE: begin
               if (q_pop) begin
                  item_ff <= q_item;
                  pos_ff  <= {1'b0, q_home};
                  if (q_item.first_of_set) begin
                     dup_seen_ff <= 1'b0;
                     // new set: advance the epoch, sweep when tags run out
                     if (epoch_ff == EPOCH_LAST) begin
                        pend_ff  <= 1'b1;
                        state_ff <= B_CLEAR;
                     end else begin
                        epoch_ff <= epoch_ff + EPOCH_W'(1);
                        state_ff <= B_READ;
                     end
                  end else begin
                     state_ff <= B_READ;
                  end
               end
            end
            B_READ: begin
               state_ff <= B_EVAL;
            end
            B_EVAL: begin
               if (hit) begin
                  dup_seen_ff <= 1'b1;
               end
               if (r_push) begin
                  state_ff <= B_IDLE;
               end else begin
                  pos_ff   <= pos_in;
                  state_ff <= B_READ;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

[hw/rtl/hashed_duplicate_detector_core.sv]
// Top level of the hashed duplicate detector: bucket-count register,
// front end, item queue, back end and result queue.
// Depends on hdd_pkg, hdd_fifo, hdd_front, hdd_back.
//
//   channel   direction  transfer when            payload
//   req_*     in         req_push && !req_full    req_value, req_first_of_set
//   rsp_*     out        rsp_pop && !rsp_empty    rsp_is_duplicate, rsp_any_duplicate,
//                                                 rsp_not_stored
//   csr_*     in         csr_valid && csr_ready   csr_bucket_count
//
// The front end takes no new item until it has handed off the last one: it accepts
// the item, runs the remainder unit (4 bits per cycle), then hands it off.
// The back end takes the item, then handles each probe as a registered memory read
// followed by a compare; a two-entry queue sits on each side.
// After reset, the back end clears the slot memory, with req_full high.
// Every 255th set start repeats that sweep when the 8-bit set epoch wraps.
// A stalled result queue holds the back end, which in turn backs up the front.
`default_nettype none

module hashed_duplicate_detector_core #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   output      logic                             req_full,
   input  wire logic signed [hdd_pkg::VALUE_W-1:0] req_value,
   input  wire logic                             req_first_of_set,
   output      logic                             rsp_empty,
   input  wire logic                             rsp_pop,
   output      logic                             rsp_is_duplicate,
   output      logic                             rsp_any_duplicate,
   output      logic                             rsp_not_stored,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [hdd_pkg::BUCKET_W-1:0]     csr_bucket_count
);
   import hdd_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int BW = AW + 1;
   localparam int CW = (BW > BUCKET_W) ? BW : BUCKET_W;
   localparam int ResetEff = (BUCKET_RESET > TABLE_DEPTH) ? TABLE_DEPTH : BUCKET_RESET;
   localparam int QW = AW + $bits(hdd_item_type);

   logic [BW-1:0]  bucket_eff_ff;
   logic [BW-1:0]  bucket_eff_in;
   logic [CW-1:0]  bucket_ext;

   hdd_item_type   req_item;
   logic           hold;
   logic           fq_push;
   hdd_item_type   fq_item;
   logic [AW-1:0]  fq_home;
   logic           fq_full;
   logic [QW-1:0]  bq_data;
   logic           bq_empty;
   logic           bq_pop;
   logic           r_push;
   logic           r_full;
   hdd_result_type r_result;
   logic [$bits(hdd_result_type)-1:0] rsp_data;
   hdd_result_type rsp_result;

   // bucket count: zero acts as one, above the table depth saturates
   assign csr_ready  = 1'b1;
   assign bucket_ext = CW'(csr_bucket_count);
   always_comb begin
      if (bucket_ext == '0) begin
         bucket_eff_in = BW'(1);
      end else if (bucket_ext > CW'(TABLE_DEPTH)) begin
         bucket_eff_in = BW'(TABLE_DEPTH);
      end else begin
         bucket_eff_in = bucket_ext[BW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_eff_ff <= BW'(ResetEff);
      end else if (csr_valid && csr_ready) begin
         bucket_eff_ff <= bucket_eff_in;
      end
   end

   assign req_item = '{value: req_value, first_of_set: req_first_of_set};

   hdd_front #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .item       (req_item),
      .full       (req_full),
      .hold       (hold),
      .bucket_eff (bucket_eff_ff),
      .q_push     (fq_push),
      .q_item     (fq_item),
      .q_home     (fq_home),
      .q_full     (fq_full)
   );

   // item queue between front and back
   hdd_fifo #(
      .WIDTH (QW)
   ) u_item_q (
      .clock   (clock),
      .reset   (reset),
      .push    (fq_push),
      .wr_data ({fq_home, fq_item}),
      .full    (fq_full),
      .pop     (bq_pop),
      .rd_data (bq_data),
      .empty   (bq_empty)
   );

   hdd_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .bucket_eff (bucket_eff_ff),
      .q_empty    (bq_empty),
      .q_pop      (bq_pop),
      .q_item     (hdd_item_type'(bq_data[$bits(hdd_item_type)-1:0])),
      .q_home     (bq_data[QW-1:$bits(hdd_item_type)]),
      .r_full     (r_full),
      .r_push     (r_push),
      .r_result   (r_result),
      .clearing   (hold)
   );

   // result queue
   hdd_fifo #(
      .WIDTH ($bits(hdd_result_type))
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (r_push),
      .wr_data (r_result),
      .full    (r_full),
      .pop     (rsp_pop),
      .rd_data (rsp_data),
      .empty   (rsp_empty)
   );

   assign rsp_result        = hdd_result_type'(rsp_data);
   assign rsp_is_duplicate  = rsp_result.is_duplicate;
   assign rsp_any_duplicate = rsp_result.any_duplicate;
   assign rsp_not_stored    = rsp_result.not_stored;

endmodule

`default_nettype wire
